// File: sv/mrsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrsh_pkg: shared types and constants for the multiply-rotate stream hash
// Lane multipliers, seed, avalanche constants, datapath ops and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package mrsh_pkg;

  localparam logic [63:0] SEED  = 64'h9E37_79B1_85EB_CA87;
  localparam logic [63:0] MIX_A = 64'hFF51_AFD7_ED55_8CCD;
  localparam logic [63:0] MIX_B = 64'hC4CE_B9FE_1A85_EC53;

  localparam logic [63:0] LANE_MUL [4] = '{
    64'hC2B2_AE3D_27D4_EB4F, 64'h1656_6791_9E37_79F9,
    64'h85EB_CA77_C2B2_AE63, 64'h27D4_EB2F_1656_67C5
  };

  localparam int ROT_L = 31;
  localparam int SHR_A = 33;

  localparam logic [3:0] FULL_BYTES = 4'd8;

  // Datapath operation; each one uses the shared multiplier once
  typedef enum logic [1:0] {
    OP_LANE = 2'd0,   // hash = rotl31(hash ^ word * lane_mul)
    OP_BYTE = 2'd1,   // hash = (hash ^ byte) * seed
    OP_AV1  = 2'd2,   // hash = (hash ^ hash >> 33) * mix_a
    OP_AV2  = 2'd3    // hash = (hash ^ hash >> 33) * mix_b
  } op_t;

  typedef struct packed {
    logic       accept;   // input transfer this cycle
    logic       start;    // launch a multiply
    logic       apply;    // multiply done, write back per op
    logic       finish;   // load result register, restart message
    op_t        op;
    logic [1:0] lane;
    logic [4:0] bidx;     // byte index into the tail
  } mrsh_cmd_t;

  typedef struct packed {
    logic       chunk_go;  // a full chunk waits to be folded
    logic       last;      // current item closes the message
    logic [4:0] tail_len;  // bytes to fold one at a time
    logic       mul_done;
    logic       out_free;  // result register can take a new value
  } mrsh_sts_t;

endpackage

// File: sv/mrsh_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrsh_mul: iterative 64x64 multiplier, low 64 bits of the product
// One 32x32 multiplier, three steps: lo*lo, lo*hi, hi*lo.
// ----------------------------------------------------------------------------
module mrsh_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);
  import mrsh_pkg::*;

  logic [63:0] a_r, b_r, acc_r, acc_nxt;
  logic [1:0]  step_r;
  logic        busy_r, done_r;
  logic [31:0] x, y;
  logic [63:0] p;

  always_comb begin
    x = (step_r == 2'd2) ? a_r[63:32] : a_r[31:0];
    y = (step_r == 2'd1) ? b_r[63:32] : b_r[31:0];
    p = {32'b0, x} * {32'b0, y};
    if (step_r == 2'd0) begin
      acc_nxt = p;
    end else begin
      acc_nxt = acc_r + {p[31:0], 32'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= !start && busy_r && (step_r == 2'd2);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        if (step_r == 2'd2) begin
          busy_r <= 1'b0;
          step_r <= 2'd0;
        end else begin
          step_r <= step_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy_r && !start) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: sv/mrsh_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrsh_dp: hash datapath
// Running hash, held chunk words, byte total, operand select, shared
// multiplier and the result register.
// ----------------------------------------------------------------------------
module mrsh_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mrsh_pkg::mrsh_cmd_t  cmd,
  output mrsh_pkg::mrsh_sts_t  sts,
  input  logic [63:0]          in_data_word,
  input  logic [3:0]           in_byte_count,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          out_hash_value,
  output logic [31:0]          out_message_length
);
  import mrsh_pkg::*;

  logic [63:0] hash_r;
  logic [63:0] pend_r [3];
  logic [1:0]  pend_cnt_r;
  logic [31:0] total_r;
  logic [63:0] word_r;
  logic [3:0]  cnt_r;
  logic        last_r;
  logic        chunk_go_r;
  logic [63:0] out_hash_r;
  logic [31:0] out_len_r;
  logic        out_valid_r;

  logic [3:0]  in_cnt;
  logic        in_full;
  logic [1:0]  sel;
  logic [63:0] word_sel;
  logic [7:0]  byte_sel;
  logic [63:0] mul_a, mul_b, prod;
  logic        mul_done;
  logic [63:0] lane_mix;
  logic [4:0]  part_len;

  // Oversized counts and non-final words count as full
  assign in_cnt  = (!in_last || in_byte_count > FULL_BYTES) ? FULL_BYTES : in_byte_count;
  assign in_full = (in_cnt == FULL_BYTES);

  // Held words come first, then the current word
  always_comb begin
    sel = (cmd.op == OP_LANE) ? cmd.lane : cmd.bidx[4:3];
    word_sel = word_r;
    if (sel < pend_cnt_r) begin
      case (sel)
        2'd0:    word_sel = pend_r[0];
        2'd1:    word_sel = pend_r[1];
        2'd2:    word_sel = pend_r[2];
        default: word_sel = word_r;
      endcase
    end
    byte_sel = word_sel[{cmd.bidx[2:0], 3'b000} +: 8];
  end

  always_comb begin
    case (cmd.op)
      OP_LANE: begin
        mul_a = word_sel;
        mul_b = LANE_MUL[cmd.lane];
      end
      OP_BYTE: begin
        mul_a = hash_r ^ {56'b0, byte_sel};
        mul_b = SEED;
      end
      OP_AV1: begin
        mul_a = hash_r ^ (hash_r >> SHR_A);
        mul_b = MIX_A;
      end
      OP_AV2: begin
        mul_a = hash_r ^ (hash_r >> SHR_A);
        mul_b = MIX_B;
      end
      default: begin
        mul_a = hash_r;
        mul_b = SEED;
      end
    endcase
  end

  mrsh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  assign lane_mix = hash_r ^ prod;
  assign part_len = (last_r && cnt_r != FULL_BYTES) ? {1'b0, cnt_r} : 5'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= SEED;
      pend_cnt_r  <= 2'd0;
      total_r     <= 32'd0;
      cnt_r       <= 4'd0;
      last_r      <= 1'b0;
      chunk_go_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.accept) begin
        cnt_r   <= in_cnt;
        last_r  <= in_last;
        total_r <= total_r + {28'b0, in_cnt};
        if (in_full) begin
          if (pend_cnt_r == 2'd3) begin
            chunk_go_r <= 1'b1;
          end else begin
            pend_cnt_r <= pend_cnt_r + 2'd1;
          end
        end
      end
      if (cmd.apply) begin
        case (cmd.op)
          OP_LANE: begin
            hash_r <= {lane_mix[63-ROT_L:0], lane_mix[63:64-ROT_L]};
            if (cmd.lane == 2'd3) begin
              chunk_go_r <= 1'b0;
              pend_cnt_r <= 2'd0;
            end
          end
          default: hash_r <= prod;
        endcase
      end
      if (cmd.finish) begin
        hash_r      <= SEED;
        pend_cnt_r  <= 2'd0;
        total_r     <= 32'd0;
        last_r      <= 1'b0;
        cnt_r       <= 4'd0;
        chunk_go_r  <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word_r <= in_data_word;
      if (in_full) begin
        for (int i = 0; i < 3; i++) begin
          if (pend_cnt_r == 2'(i)) begin
            pend_r[i] <= in_data_word;
          end
        end
      end
    end
    if (cmd.finish) begin
      out_hash_r <= hash_r ^ (hash_r >> SHR_A);
      out_len_r  <= total_r;
    end
  end

  always_comb begin
    sts.chunk_go = chunk_go_r;
    sts.last     = last_r;
    sts.tail_len = {pend_cnt_r, 3'b000} + part_len;
    sts.mul_done = mul_done;
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid          = out_valid_r;
  assign out_hash_value     = out_hash_r;
  assign out_message_length = out_len_r;

endmodule

// File: sv/mrsh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrsh_ctrl: sequencing state machine
// Steps the datapath through chunk lanes, tail bytes and the avalanche.
// ----------------------------------------------------------------------------
module mrsh_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mrsh_pkg::mrsh_sts_t  sts,
  output mrsh_pkg::mrsh_cmd_t  cmd
);
  import mrsh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_NEXT = 4'b0010,
    S_WAIT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  op_t        op_r, op_nxt;
  logic [1:0] lane_r, lane_nxt;
  logic [4:0] bidx_r, bidx_nxt;
  logic [1:0] av_r, av_nxt;
  logic       start;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    lane_nxt  = lane_r;
    bidx_nxt  = bidx_r;
    av_nxt    = av_r;
    start     = 1'b0;
    cmd       = '0;
    cmd.lane  = lane_r;
    cmd.bidx  = bidx_r;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts.chunk_go) begin
          op_nxt = OP_LANE;
          start  = 1'b1;
        end else if (!sts.last) begin
          state_nxt = S_IDLE;
        end else if (bidx_r != sts.tail_len) begin
          op_nxt = OP_BYTE;
          start  = 1'b1;
        end else if (av_r == 2'd0) begin
          op_nxt = OP_AV1;
          start  = 1'b1;
        end else if (av_r == 2'd1) begin
          op_nxt = OP_AV2;
          start  = 1'b1;
        end else begin
          state_nxt = S_OUT;
        end
        if (start) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts.mul_done) begin
          cmd.apply = 1'b1;
          state_nxt = S_NEXT;
          case (op_r)
            OP_LANE: lane_nxt = lane_r + 2'd1;
            OP_BYTE: bidx_nxt = bidx_r + 5'd1;
            default: av_nxt   = av_r + 2'd1;
          endcase
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
          lane_nxt   = 2'd0;
          bidx_nxt   = 5'd0;
          av_nxt     = 2'd0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.start = start;
    cmd.op    = (state_r == S_NEXT) ? op_nxt : op_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_LANE;
      lane_r  <= 2'd0;
      bidx_r  <= 5'd0;
      av_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      lane_r  <= lane_nxt;
      bidx_r  <= bidx_nxt;
      av_r    <= av_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// File: sv/multiply_rotate_stream_hash64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiply_rotate_stream_hash64: streaming 64-bit multiply-rotate hash
// Folds 32-byte chunks lane by lane, folds leftover bytes one at a time on
// the last word, then avalanches and reports hash and length.
// ----------------------------------------------------------------------------
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   input   | in_valid, in_stall, in_data_word,              | in
//           | in_byte_count, in_last                        |
//   result  | out_valid, out_stall, out_hash_value,          | out
//           | out_message_length                            |
//
// Operation: every 64x64 multiply goes through one shared 32x32 multiplier in
// three steps, so each hash operation is an issue, the three steps and a write
// back. A word that does not close a chunk is only stored; a word that closes
// a chunk adds four lane folds. A last item adds one fold per leftover byte,
// the two avalanche multiplies and the load of the result register.
// Reset: synchronous, active low; the hash restarts from the seed and no
// result is pending. A stalled result sits in the output register while the
// next message is already being taken in; only finishing that next message
// waits for the register to free up.
// ----------------------------------------------------------------------------
module multiply_rotate_stream_hash64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value,
  output logic [31:0] out_message_length
);
  import mrsh_pkg::*;

  // command and status between sequencer and datapath
  mrsh_cmd_t cmd;
  mrsh_sts_t sts;

  // Sequencer: accepts a transfer, then walks chunk lanes, tail bytes and
  // the two avalanche multiplies before loading the result register.
  mrsh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: hash state, held words, byte counter, multiplier, result.
  mrsh_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_data_word       (in_data_word),
    .in_byte_count      (in_byte_count),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hash_value     (out_hash_value),
    .out_message_length (out_message_length)
  );

endmodule

// File: tb/tb_multiply_rotate_stream_hash64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiply_rotate_stream_hash64: self-checking bench for the stream hash
// Streams whole messages into the hasher. Expected digests are computed
// alongside by a bit-accurate predictor at each input transfer. Every
// result transfer is checked against the oldest digest still outstanding.
// Coverage: directed corner messages, random traffic under three
// sender/receiver idling mixes, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_multiply_rotate_stream_hash64;
  import mrsh_pkg::*;

  localparam int HOLD_CYCLES     = 400;  // long receiver hold-off
  localparam int SETTLE_CYCLES   = 200;  // wait for stray results before the verdict
  localparam int ITEMS_PER_PHASE = 600;  // three random phases, about 1800 items

  typedef struct packed {
    logic [63:0] hash;
    logic [31:0] len;
  } digest_t;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_stall;
  logic [63:0] in_data_word       = '0;
  logic [3:0]  in_byte_count      = '0;
  logic        in_last            = 1'b0;
  logic        out_valid;
  logic        out_stall          = 1'b0;
  logic [63:0] out_hash_value;
  logic [31:0] out_message_length;

  // Idling percentages, set per test
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long hold-off requests: tests bump hold_asked, the receiver counts it out
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left  = 0;

  int fail_cnt = 0;

  // Predictor state: open message as seen at the input
  logic [63:0] acc_hash = SEED;
  logic [63:0] held_word [3] = '{default: '0};
  int unsigned held_cnt = 0;
  logic [31:0] byte_sum = '0;

  // Digests of closed messages, oldest first
  digest_t digest_q [$];
  digest_t want;

  multiply_rotate_stream_hash64 u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_word       (in_data_word),
    .in_byte_count      (in_byte_count),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hash_value     (out_hash_value),
    .out_message_length (out_message_length)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Byte-serial tail fold: xor one byte, multiply by the seed
  function automatic logic [63:0] fold_bytes(input logic [63:0] h0,
                                             input logic [63:0] w,
                                             input int unsigned n);
    logic [63:0] h;
    h = h0;
    for (int unsigned b = 0; b < n; b++) h = (h ^ {56'd0, w[8*b +: 8]}) * SEED;
    return h;
  endfunction

  // Applies one accepted input transfer to the predictor state; on a last
  // item the digest is queued and the state goes back to its reset values.
  function automatic void absorb_word(input logic [63:0] data,
                                      input logic [3:0]  cnt,
                                      input logic        is_last);
    int unsigned nbytes;
    logic [63:0] h;
    digest_t     d;
    // Short counts only matter on the last item; anything above 8 is 8
    nbytes = (is_last && cnt < FULL_BYTES) ? cnt : 8;
    byte_sum += nbytes;
    if (nbytes == 8) begin
      if (held_cnt == 3) begin
        // Chunk complete: lane folds in order 0..3, each followed by rotl 31
        h = acc_hash;
        for (int ln = 0; ln < 4; ln++) begin
          if (ln < 3) h ^= held_word[ln] * LANE_MUL[ln];
          else h ^= data * LANE_MUL[ln];
          h = (h << ROT_L) | (h >> (64 - ROT_L));
        end
        acc_hash = h;
        held_cnt = 0;
      end else begin
        held_word[held_cnt] = data;
        held_cnt++;
      end
    end
    if (is_last) begin
      h = acc_hash;
      for (int unsigned i = 0; i < held_cnt; i++) h = fold_bytes(h, held_word[i], 8);
      if (nbytes < 8) h = fold_bytes(h, data, nbytes);
      // Avalanche
      h ^= h >> SHR_A;
      h = h * MIX_A;
      h ^= h >> SHR_A;
      h = h * MIX_B;
      h ^= h >> SHR_A;
      d.hash = h;
      d.len  = byte_sum;
      digest_q.push_back(d);
      acc_hash = SEED;
      held_cnt = 0;
      byte_sum = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stall, or a long hold-off when a test asks for one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: values are sampled as they stood before the edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $display("%0t: result with nothing outstanding: hash %h length %0d",
                 $time, out_hash_value, out_message_length);
        fail_cnt++;
      end else begin
        want = digest_q.pop_front();
        if (out_hash_value !== want.hash) begin
          $display("%0t: hash_value mismatch: expected %h actual %h",
                   $time, want.hash, out_hash_value);
          fail_cnt++;
        end
        if (out_message_length !== want.len) begin
          $display("%0t: message_length mismatch: expected %0d actual %0d",
                   $time, want.len, out_message_length);
          fail_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // One input transfer: optional idle gap, then hold the item until taken.
  // Valid stays high on return so back-to-back items need no extra edge.
  task automatic send_word(input logic [63:0] data, input logic [3:0] cnt,
                           input logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= data;
    in_byte_count <= cnt;
    in_last       <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_word(data, cnt, is_last);
  endtask

  // Random word with the all-zero and all-one patterns mixed in
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // A message of n_full non-last words closed by a last word of last_cnt.
  // Now and then a non-last word carries a short or oversized count, which
  // the block must treat as a full word.
  task automatic send_message(input int n_full, input logic [3:0] last_cnt);
    logic [3:0] cnt;
    for (int k = 0; k < n_full; k++) begin
      cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : FULL_BYTES;
      send_word(rand_word(), cnt, 1'b0);
    end
    send_word(rand_word(), last_cnt, 1'b1);
  endtask

  // Sender pause: drop valid and wait until every digest has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner messages: empty, single word, oversized and short counts,
  // junk above the valid bytes, longest tail, exact chunk, chunk plus word
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // empty message; data bits must be ignored
    send_word('1, 4'd0, 1'b1);
    send_word('0, FULL_BYTES, 1'b1);
    // count above 8 on a last item acts as 8
    send_word('1, 4'd15, 1'b1);
    // one valid byte, junk above it
    send_word(64'hFFFF_FFFF_FFFF_FFAB, 4'd1, 1'b1);
    // short non-last word counts as full; empty last item
    send_word(64'h0123_4567_89AB_CDEF, 4'd3, 1'b0);
    send_word('1, 4'd0, 1'b1);
    // three held words plus seven bytes: the longest tail
    send_word(64'h8000_0000_0000_0001, 4'd12, 1'b0);
    send_word('1, 4'd0, 1'b0);
    send_word('0, FULL_BYTES, 1'b0);
    send_word('1, 4'd7, 1'b1);
    // exactly one chunk, then an empty last item
    repeat (4) send_word(rand_word(), FULL_BYTES, 1'b0);
    send_word(rand_word(), 4'd0, 1'b1);
    // one chunk and one more full word closing the message
    repeat (4) send_word(rand_word(), FULL_BYTES, 1'b0);
    send_word('1, FULL_BYTES, 1'b1);
    wait_drain();
  endtask

  // Random messages, mostly short so tails of every length show up often
  task automatic test_random_traffic(input int n_items, input int sp, input int rp);
    int         sent;
    int         n_full;
    logic [3:0] last_cnt;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    sent = 0;
    while (sent < n_items) begin
      n_full = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 40)
                                            : $urandom_range(0, 11);
      last_cnt = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
      send_message(n_full, last_cnt);
      sent += n_full + 1;
    end
    wait_drain();
  endtask

  // Receiver holds off for a long stretch while messages keep coming:
  // the output register fills, the next message closes and input stalls.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked++;
    for (int m = 0; m < 4; m++) send_message(5, 4'($urandom_range(0, 8)));
    wait_drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(ITEMS_PER_PHASE, 32, 62);
    test_random_traffic(ITEMS_PER_PHASE, 62, 32);
    test_random_traffic(ITEMS_PER_PHASE, 0, 0);
    test_back_pressure();
    // let any stray result show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && digest_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: 10 ms is many times the slowest legal run
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: files.f
sv/mrsh_pkg.sv
sv/mrsh_mul.sv
sv/mrsh_dp.sv
sv/mrsh_ctrl.sv
sv/multiply_rotate_stream_hash64.sv
tb/tb_multiply_rotate_stream_hash64.sv
